// ----- rtl/core/ddtw_pkg.sv -----
// Package for the decimal digit tile writer: widths, power-of-ten tables and state codes.
package ddtw_pkg;

  localparam int unsigned MAX_PLACES = 6;
  localparam int unsigned VAL_W      = 20;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned ART_W      = 10;
  localparam int unsigned PLACE_W    = 3;

  localparam logic [ADDR_W-1:0]  POS_STRIDE = 16'd64;
  localparam logic [PLACE_W-1:0] LAST_PLACE = 3'(MAX_PLACES - 1);
  localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_DIGIT = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  // Power of ten for a place index; place 0 is the hundred-thousands
  function automatic logic [VAL_W-1:0] place_power(input logic [PLACE_W-1:0] place);
    logic [VAL_W-1:0] p;
    unique case (place)
      3'd0:    p = 20'd100000;
      3'd1:    p = 20'd10000;
      3'd2:    p = 20'd1000;
      3'd3:    p = 20'd100;
      3'd4:    p = 20'd10;
      default: p = 20'd1;
    endcase
    return p;
  endfunction

  // Overflow bound for a top place: ten times its power
  function automatic logic [VAL_W-1:0] place_bound(input logic [PLACE_W-1:0] place);
    logic [VAL_W-1:0] p;
    unique case (place)
      3'd0:    p = 20'd1000000;
      3'd1:    p = 20'd100000;
      3'd2:    p = 20'd10000;
      3'd3:    p = 20'd1000;
      3'd4:    p = 20'd100;
      default: p = 20'd10;
    endcase
    return p;
  endfunction

endpackage

// ----- rtl/core/ddtw_in_if.sv -----
// Input channel: one number to convert per beat.
interface ddtw_in_if import ddtw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VAL_W-1:0]   value;
  logic [ADDR_W-1:0]  start_address;
  logic [PLACE_W-1:0] first_place;
  logic [PLACE_W-1:0] places_less_one;
  logic               suppress_leading;

  modport source (
    output valid, value, start_address, first_place, places_less_one, suppress_leading,
    input  ready
  );
  modport sink (
    input  valid, value, start_address, first_place, places_less_one, suppress_leading,
    output ready
  );
endinterface

// ----- rtl/core/ddtw_out_if.sv -----
// Output channel: one digit position record per beat.
interface ddtw_out_if import ddtw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  address;
  logic [DIGIT_W-1:0] digit;
  logic               write_enable;
  logic [ART_W-1:0]   art_offset;
  logic               last;

  modport source (
    output valid, address, digit, write_enable, art_offset, last,
    input  ready
  );
  modport sink (
    input  valid, address, digit, write_enable, art_offset, last,
    output ready
  );
endinterface

// ----- rtl/core/decimal_digit_tile_writer_core.sv -----
// Top level: sequencer that turns a binary number into per-position digit records.
//
// Usage
//   in_i  : one beat per number (value, start address, top place, place count,
//           leading-zero suppress). Accepted when valid and ready are both high.
//   out_o : one beat per digit position, most significant first; last marks the
//           final position of the number.
//   Digits come from repeated subtraction of the place's power of ten in one
//   shared subtractor. A number starts with a setup step (overflow check against
//   ten times the top power), then for each position: one subtraction per unit
//   of the digit, one failing compare, and a load of the output register. A
//   saturated number skips the subtractions and emits a nine at each position.
//   A load waits while the receiver stalls the output register.
//   in_i.ready is high only while the sequencer is idle; the final record may
//   still sit in the output register while the next number is accepted.
//   A stalled receiver holds the output register and the sequencer waits.
//   Reset (rst_ni low, asynchronous) returns to idle with no output pending.
module decimal_digit_tile_writer_core import ddtw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ddtw_in_if.sink     in_i,
  ddtw_out_if.source  out_o
);

  state_e state_q, state_d;

  logic [VAL_W-1:0]   rem_q, rem_d;
  logic [PLACE_W-1:0] place_q, place_d;
  logic [PLACE_W-1:0] pos_q, pos_d;
  logic [PLACE_W-1:0] cnt_q, cnt_d;
  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic               sat_q, sat_d;
  logic               seen_q, seen_d;
  logic               sup_q, sup_d;

  // Output register
  logic               ovalid_q, ovalid_d;
  logic [ADDR_W-1:0]  oaddr_q;
  logic [DIGIT_W-1:0] odigit_q;
  logic               owe_q;
  logic               olast_q;
  logic               oload;

  // Shared unit operands
  logic [VAL_W-1:0]   sub_b;
  logic [VAL_W-1:0]   sub_diff;
  logic               sub_ge;

  // Input clamping
  logic [PLACE_W-1:0] first_c;
  logic [PLACE_W-1:0] avail;
  logic               in_fire;
  logic               nonzero;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign nonzero    = (digit_q != '0);

  always_comb begin
    first_c = (in_i.first_place >= PLACE_W'(MAX_PLACES)) ? LAST_PLACE : in_i.first_place;
    avail   = LAST_PLACE - first_c;
  end

  // Second operand: overflow bound during setup, place power otherwise
  assign sub_b = (state_q == ST_SETUP) ? place_bound(place_q) : place_power(place_q);

  ddtw_sub_unit u_sub (
    .a_i    (rem_q),
    .b_i    (sub_b),
    .diff_o (sub_diff),
    .ge_o   (sub_ge)
  );

  // Output slot free, or emptied this cycle
  assign oload = (state_q == ST_EMIT) && (!ovalid_q || out_o.ready);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    rem_d    = rem_q;
    place_d  = place_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    digit_d  = digit_q;
    addr_d   = addr_q;
    sat_d    = sat_q;
    seen_d   = seen_q;
    sup_d    = sup_q;
    ovalid_d = ovalid_q && !out_o.ready;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          rem_d   = in_i.value;
          place_d = first_c;
          cnt_d   = (in_i.places_less_one < avail) ? in_i.places_less_one : avail;
          pos_d   = '0;
          addr_d  = in_i.start_address;
          sup_d   = in_i.suppress_leading;
          seen_d  = 1'b0;
          digit_d = '0;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        sat_d   = sub_ge;
        state_d = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (sat_q) begin
          digit_d = DIGIT_MAX;
          state_d = ST_EMIT;
        end else if (sub_ge) begin
          rem_d   = sub_diff;
          digit_d = digit_q + 4'd1;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (oload) begin
          ovalid_d = 1'b1;
          seen_d   = seen_q || nonzero;
          digit_d  = '0;
          if (pos_q == cnt_q) begin
            state_d = ST_IDLE;
          end else begin
            pos_d   = pos_q + 3'd1;
            place_d = place_q + 3'd1;
            addr_d  = addr_q + POS_STRIDE;
            state_d = ST_DIGIT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
      digit_q  <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      digit_q  <= digit_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    place_q <= place_d;
    addr_q  <= addr_d;
    sat_q   <= sat_d;
    seen_q  <= seen_d;
    sup_q   <= sup_d;
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (oload) begin
      oaddr_q  <= addr_q;
      odigit_q <= digit_q;
      owe_q    <= !sup_q || seen_q || nonzero;
      olast_q  <= (pos_q == cnt_q);
    end
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.address      = oaddr_q;
  assign out_o.digit        = odigit_q;
  assign out_o.write_enable = owe_q;
  assign out_o.art_offset   = {odigit_q, 6'b0};
  assign out_o.last         = olast_q;

  // Checks
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_q <= DIGIT_MAX)
    else $error("digit register beyond nine");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= cnt_q)
    else $error("position counter past the last position");

  a_accept_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_SETUP)
    else $error("accepted number did not enter setup");

  a_sat_nines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT && sat_q) |=> (state_q == ST_EMIT && digit_q == DIGIT_MAX))
    else $error("saturated number did not produce a nine");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oload && pos_q == cnt_q) |=> (state_q == ST_IDLE && out_o.last))
    else $error("final record did not end the number");

endmodule

// ----- rtl/core/ddtw_sub_unit.sv -----
// Shared subtract and compare unit used for both the overflow check and digit extraction.
module ddtw_sub_unit import ddtw_pkg::*; (
  input  logic [VAL_W-1:0] a_i,
  input  logic [VAL_W-1:0] b_i,
  output logic [VAL_W-1:0] diff_o,
  output logic             ge_o
);

  logic [VAL_W:0] full;

  // One wide subtract; no borrow means a >= b
  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[VAL_W-1:0];
  assign ge_o   = ~full[VAL_W];

endmodule
